// ===== src/dirty_bitmap_region_coalescer_assert.svh =====
// Assertion macros shared by the checkers of the dirty bitmap coalescer.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef DIRTY_BITMAP_REGION_COALESCER_ASSERT_SVH
`define DIRTY_BITMAP_REGION_COALESCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DBRC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DBRC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dbrc_pkg.sv =====
`default_nettype none

package dbrc_pkg;

    localparam int ENTRIES    = 128;
    localparam int WORD_BITS  = 64;
    localparam int WORD_COUNT = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
    localparam int WADDR_W    = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int IDX_W      = 7;
    localparam int RIDX_W     = 8;
    localparam int EB_W       = 13;
    localparam int LIMIT_W    = 8;
    localparam int FIELD_W    = 20;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [1:0] {
        FUNC_MARK  = 2'd0,
        FUNC_WIDEN = 2'd1,
        FUNC_FLUSH = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ELEMENT_BYTES = 1'b0,
        CFG_INDEX_LIMIT   = 1'b1
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MARK,
        ST_FETCH,
        ST_SCAN,
        ST_DONE
    } state_t;

    // One result request from the sequencer to the output stage.
    typedef struct packed {
        logic              strobe;
        logic              valid;
        logic              is_last;
        logic [RIDX_W-1:0] first_idx;
        logic [RIDX_W-1:0] end_idx;
    } emit_t;

endpackage

`default_nettype wire

// ===== src/dbrc_ram.sv =====
`default_nettype none

module dbrc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 2
) (
    input  wire logic                                      clk,
    input  wire logic                                      wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                          wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== src/dbrc_seq.sv =====
`default_nettype none

module dbrc_seq (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic [1:0]                            func,
    input  wire logic [dbrc_pkg::IDX_W-1:0]            element_index,
    input  wire logic [dbrc_pkg::LIMIT_W-1:0]          index_limit,
    input  wire logic                                  eb_zero,
    output logic                                       busy,
    output logic      [dbrc_pkg::WADDR_W-1:0]          rd_addr,
    input  wire logic [dbrc_pkg::WORD_BITS-1:0]        rd_data,
    output logic                                       wr_en,
    output logic      [dbrc_pkg::WADDR_W-1:0]          wr_addr,
    output logic      [dbrc_pkg::WORD_BITS-1:0]        wr_data,
    output dbrc_pkg::emit_t                            emit
);

    localparam int WB = dbrc_pkg::WORD_BITS;
    localparam int BW = dbrc_pkg::BIT_W;
    localparam int RW = dbrc_pkg::RIDX_W;
    localparam int AW = dbrc_pkg::WADDR_W;

    function automatic logic [BW:0] lowest_set(input logic [WB-1:0] v);
        logic [BW:0] r;
        r = (BW + 1)'(WB);
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = (BW + 1)'(i);
            end
        end
        return r;
    endfunction

    function automatic logic [WB-1:0] low_mask(input logic [BW:0] n);
        logic [WB:0] m;
        m = ((WB + 1)'(1) << n) - (WB + 1)'(1);
        return m[WB-1:0];
    endfunction

    dbrc_pkg::state_t state_reg, state_next;
    logic [AW-1:0]                   word_reg, word_next;
    logic [BW-1:0]                   bit_reg, bit_next;
    logic [WB-1:0]                   cur_reg, cur_next;
    logic                            open_reg, open_next;
    logic [RW-1:0]                   first_reg, first_next;
    logic [RW-1:0]                   end_reg, end_next;
    logic [dbrc_pkg::WORD_COUNT-1:0] flags_reg, flags_next;
    logic [RW-1:0]                   rs_reg, rs_next;
    logic [RW-1:0]                   re_reg, re_next;
    logic                            rp_reg, rp_next;

    logic [RW-1:0] idx_ext;
    logic [RW-1:0] idx_end;
    logic [RW-1:0] wid_start;
    logic [RW-1:0] wid_end;
    logic [WB-1:0] fetched;
    logic [RW-1:0] base;
    logic [RW:0]   lim_diff;
    logic [WB-1:0] lim_mask;
    logic [BW:0]   run_p;
    logic [BW:0]   run_q;
    logic [RW-1:0] run_first;
    logic [RW-1:0] run_end;
    logic          merge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dbrc_pkg::ST_IDLE;
            flags_reg <= '0;
            rs_reg    <= '0;
            re_reg    <= '0;
            rp_reg    <= 1'b0;
            open_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flags_reg <= flags_next;
            rs_reg    <= rs_next;
            re_reg    <= re_next;
            rp_reg    <= rp_next;
            open_reg  <= open_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        bit_reg   <= bit_next;
        cur_reg   <= cur_next;
        first_reg <= first_next;
        end_reg   <= end_next;
    end

    // Range after widening by the incoming index.
    always_comb
    begin
        idx_ext = RW'(element_index);
        idx_end = idx_ext + RW'(1);
        if (!rp_reg)
        begin
            wid_start = idx_ext;
            wid_end   = idx_end;
        end
        else
        begin
            wid_start = (idx_ext < rs_reg) ? idx_ext : rs_reg;
            wid_end   = (idx_end > re_reg) ? idx_end : re_reg;
        end
    end

    // A word that was never marked since the last clear reads as zero.
    assign fetched = flags_reg[word_reg] ? rd_data : '0;

    // Qualifying bits of the current word: global index below index_limit.
    always_comb
    begin
        base     = RW'({word_reg, {BW{1'b0}}});
        lim_diff = {1'b0, index_limit} - {1'b0, base};
        if (index_limit <= base)
        begin
            lim_mask = '0;
        end
        else if (lim_diff >= (RW + 1)'(WB))
        begin
            lim_mask = '1;
        end
        else
        begin
            lim_mask = low_mask(lim_diff[BW:0]);
        end
    end

    // Lowest run of set bits in the current word: [run_p, run_q).
    always_comb
    begin
        run_p     = lowest_set(cur_reg);
        run_q     = lowest_set(~(cur_reg | low_mask(run_p)));
        run_first = base + RW'(run_p);
        run_end   = base + RW'(run_q);
        merge     = open_reg && (eb_zero || (run_first == end_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        word_next  = word_reg;
        bit_next   = bit_reg;
        cur_next   = cur_reg;
        open_next  = open_reg;
        first_next = first_reg;
        end_next   = end_reg;
        flags_next = flags_reg;
        rs_next    = rs_reg;
        re_next    = re_reg;
        rp_next    = rp_reg;
        rd_addr    = word_reg;
        wr_en      = 1'b0;
        wr_addr    = word_reg;
        wr_data    = fetched | (WB'(1) << bit_reg);
        emit       = '0;

        unique case (state_reg)
            dbrc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (func)
                        dbrc_pkg::FUNC_MARK:
                        begin
                            rs_next    = wid_start;
                            re_next    = wid_end;
                            rp_next    = 1'b1;
                            bit_next   = element_index[BW-1:0];
                            word_next  = AW'(element_index >> BW);
                            rd_addr    = AW'(element_index >> BW);
                            state_next = dbrc_pkg::ST_MARK;
                        end
                        dbrc_pkg::FUNC_WIDEN:
                        begin
                            rs_next = wid_start;
                            re_next = wid_end;
                            rp_next = 1'b1;
                        end
                        dbrc_pkg::FUNC_FLUSH:
                        begin
                            if (|flags_reg)
                            begin
                                word_next  = '0;
                                rd_addr    = '0;
                                open_next  = 1'b0;
                                state_next = dbrc_pkg::ST_FETCH;
                            end
                            else if (rp_reg)
                            begin
                                emit.strobe    = 1'b1;
                                emit.valid     = 1'b1;
                                emit.is_last   = 1'b1;
                                emit.first_idx = rs_reg;
                                emit.end_idx   = re_reg;
                                rs_next        = '0;
                                re_next        = '0;
                                rp_next        = 1'b0;
                            end
                            else
                            begin
                                emit.strobe  = 1'b1;
                                emit.is_last = 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            dbrc_pkg::ST_MARK:
            begin
                wr_en                = 1'b1;
                flags_next[word_reg] = 1'b1;
                state_next           = dbrc_pkg::ST_IDLE;
            end
            dbrc_pkg::ST_FETCH:
            begin
                cur_next   = fetched & lim_mask;
                state_next = dbrc_pkg::ST_SCAN;
            end
            dbrc_pkg::ST_SCAN:
            begin
                if (cur_reg == '0)
                begin
                    if (word_reg == AW'(dbrc_pkg::WORD_COUNT - 1))
                    begin
                        state_next = dbrc_pkg::ST_DONE;
                    end
                    else
                    begin
                        word_next  = word_reg + AW'(1);
                        rd_addr    = word_reg + AW'(1);
                        state_next = dbrc_pkg::ST_FETCH;
                    end
                end
                else
                begin
                    cur_next = cur_reg & ~low_mask(run_q);
                    end_next = run_end;
                    if (!merge)
                    begin
                        // A new region starts, so the pending one is complete.
                        emit.strobe    = open_reg;
                        emit.valid     = 1'b1;
                        emit.first_idx = first_reg;
                        emit.end_idx   = end_reg;
                        first_next     = run_first;
                        open_next      = 1'b1;
                    end
                end
            end
            dbrc_pkg::ST_DONE:
            begin
                emit.strobe  = 1'b1;
                emit.is_last = 1'b1;
                if (open_reg)
                begin
                    emit.valid     = 1'b1;
                    emit.first_idx = first_reg;
                    emit.end_idx   = end_reg;
                    flags_next     = '0;
                    rs_next        = '0;
                    re_next        = '0;
                    rp_next        = 1'b0;
                end
                open_next  = 1'b0;
                state_next = dbrc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dbrc_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != dbrc_pkg::ST_IDLE);

endmodule

`default_nettype wire

// ===== src/dbrc_emit.sv =====
`default_nettype none

module dbrc_emit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dbrc_pkg::emit_t               req,
    input  wire logic [dbrc_pkg::EB_W-1:0]     element_bytes,
    output logic                               result_strobe,
    output logic      [dbrc_pkg::FIELD_W-1:0]  region_offset,
    output logic      [dbrc_pkg::FIELD_W-1:0]  region_size,
    output logic                               region_valid,
    output logic                               last_region
);

    localparam int PW = dbrc_pkg::RIDX_W + dbrc_pkg::EB_W;

    logic                         strobe_reg;
    logic [dbrc_pkg::FIELD_W-1:0] offset_reg;
    logic [dbrc_pkg::FIELD_W-1:0] size_reg;
    logic                         valid_reg;
    logic                         last_reg;

    logic [dbrc_pkg::RIDX_W-1:0]  len;
    logic [PW-1:0]                off_prod;
    logic [PW-1:0]                size_prod;

    // A reversed range has zero length.
    always_comb
    begin
        len       = (req.end_idx >= req.first_idx) ? (req.end_idx - req.first_idx) : '0;
        off_prod  = PW'(req.first_idx) * PW'(element_bytes);
        size_prod = PW'(len) * PW'(element_bytes);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= req.strobe;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.strobe)
        begin
            offset_reg <= off_prod[dbrc_pkg::FIELD_W-1:0];
            size_reg   <= size_prod[dbrc_pkg::FIELD_W-1:0];
            valid_reg  <= req.valid;
            last_reg   <= req.is_last;
        end
    end

    assign result_strobe = strobe_reg;
    assign region_offset = offset_reg;
    assign region_size   = size_reg;
    assign region_valid  = valid_reg;
    assign last_region   = last_reg;

endmodule

`default_nettype wire

// ===== src/dirty_bitmap_region_coalescer.sv =====
`default_nettype none

// Dirty bitmap tracker with run coalescing on flush.
// Commands enter on start/func/element_index and are taken when start is high
// and busy is low. Mark sets one bitmap bit and widens the element range; it
// does a read-modify-write of one bitmap word, so busy is high for one cycle
// after it. Widen only updates the range. Flush with no bitmap bits set
// answers from idle with the whole range as one region, or one invalid
// transaction when nothing is pending. Flush with bits set walks the bitmap
// memory word by word: per word ST_FETCH takes the word read, then ST_SCAN
// runs once per run found and once more to see the word empty, and a closing
// ST_DONE ends the walk; the bitmap has 2 words. Results come out one per
// transaction on result_strobe, registered in the cycle after the cycle that
// produced them; the last one of a flush has last_region set. The receiver
// cannot stall: every strobed transaction is taken at once. The user must
// write configuration (cfg_we/cfg_index/cfg_data) only while idle; the block
// does not enforce it. Reset clears the bitmap (through per-word valid flags)
// and the range, and loads element_bytes = 64 and index_limit = 128.
module dirty_bitmap_region_coalescer (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire logic [1:0]                         func,
    input  wire logic [dbrc_pkg::IDX_W-1:0]         element_index,
    input  wire logic                               cfg_we,
    input  wire logic [dbrc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dbrc_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic                                    result_strobe,
    output logic      [dbrc_pkg::FIELD_W-1:0]       region_offset,
    output logic      [dbrc_pkg::FIELD_W-1:0]       region_size,
    output logic                                    region_valid,
    output logic                                    last_region
);

    logic [dbrc_pkg::EB_W-1:0]    element_bytes_reg;
    logic [dbrc_pkg::LIMIT_W-1:0] index_limit_reg;

    logic                             wr_en;
    logic [dbrc_pkg::WADDR_W-1:0]     wr_addr;
    logic [dbrc_pkg::WORD_BITS-1:0]   wr_data;
    logic [dbrc_pkg::WADDR_W-1:0]     rd_addr;
    logic [dbrc_pkg::WORD_BITS-1:0]   rd_data;
    dbrc_pkg::emit_t                  emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_bytes_reg <= dbrc_pkg::EB_W'(64);
            index_limit_reg   <= dbrc_pkg::LIMIT_W'(128);
        end
        else if (cfg_we)
        begin
            unique case (dbrc_pkg::cfg_reg_t'(cfg_index))
                dbrc_pkg::CFG_ELEMENT_BYTES:
                begin
                    element_bytes_reg <= cfg_data[dbrc_pkg::EB_W-1:0];
                end
                dbrc_pkg::CFG_INDEX_LIMIT:
                begin
                    index_limit_reg <= cfg_data[dbrc_pkg::LIMIT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    dbrc_ram #(
        .WIDTH (dbrc_pkg::WORD_BITS),
        .DEPTH (dbrc_pkg::WORD_COUNT)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    dbrc_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .func          (func),
        .element_index (element_index),
        .index_limit   (index_limit_reg),
        .eb_zero       (element_bytes_reg == '0),
        .busy          (busy),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .emit          (emit)
    );

    dbrc_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (emit),
        .element_bytes (element_bytes_reg),
        .result_strobe (result_strobe),
        .region_offset (region_offset),
        .region_size   (region_size),
        .region_valid  (region_valid),
        .last_region   (last_region)
    );

endmodule

`default_nettype wire

// ===== src/dbrc_checker.sv =====
`default_nettype none

`include "dirty_bitmap_region_coalescer_assert.svh"

module dbrc_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         start,
    input wire logic                         busy,
    input wire logic [1:0]                   func,
    input wire logic                         result_strobe,
    input wire logic [dbrc_pkg::FIELD_W-1:0] region_offset,
    input wire logic [dbrc_pkg::FIELD_W-1:0] region_size,
    input wire logic                         region_valid,
    input wire logic                         last_region
);

    // An empty flush reports one closing transaction with no region.
    `DBRC_ASSERT_IMP(a_invalid_is_last, result_strobe && !region_valid, last_region && region_offset == '0 && region_size == '0, "invalid result must be last and zero")

    // More regions follow only while the bitmap walk is still running.
    `DBRC_ASSERT_IMP(a_mid_flush_busy, result_strobe && !last_region, busy, "non-last result while idle")

    // A mark needs its write-back cycle.
    `DBRC_ASSERT_NXT(a_mark_busy, start && !busy && func == dbrc_pkg::FUNC_MARK, busy, "mark did not hold busy for write-back")

    // A widen is finished at once and produces nothing.
    `DBRC_ASSERT_NXT(a_widen_quiet, start && !busy && func == dbrc_pkg::FUNC_WIDEN, !busy && !result_strobe, "widen produced a result or stalled")

endmodule

bind dirty_bitmap_region_coalescer dbrc_checker u_dbrc_checker (.*);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import dbrc_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_CMDS = 340;
    localparam int PHASE_CMDS = 60;
    localparam int IDLE_SETTLE = 10;
    localparam int DRAIN_SETTLE = 80;

    typedef struct {
        logic [FIELD_W-1:0] offset;
        logic [FIELD_W-1:0] size;
        logic               valid;
        logic               last;
    } region_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [1:0]            func = 2'd0;
    logic [IDX_W-1:0]      element_index = '0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  busy;
    logic                  result_strobe;
    logic [FIELD_W-1:0]    region_offset;
    logic [FIELD_W-1:0]    region_size;
    logic                  region_valid;
    logic                  last_region;

    // Shadow copy of the tracker state and its registers.
    logic [ENTRIES-1:0]    shadow_bits;
    logic [RIDX_W-1:0]     shadow_start;
    logic [RIDX_W-1:0]     shadow_end;
    logic                  shadow_present;
    logic [EB_W-1:0]       shadow_elem_bytes;
    logic [LIMIT_W-1:0]    shadow_limit;

    region_t pending_regions[$];
    region_t want_region;

    int mismatches = 0;
    int cycle_count = 0;
    int cmds_taken = 0;
    int regions_checked = 0;
    int configs_used = 0;
    int burst_left = 0;
    bit steady = 1'b0;

    dirty_bitmap_region_coalescer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .func          (func),
        .element_index (element_index),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result_strobe (result_strobe),
        .region_offset (region_offset),
        .region_size   (region_size),
        .region_valid  (region_valid),
        .last_region   (last_region)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= 20)
            $display("tb: mismatch at %0t on %s: got 0x%0h, want 0x%0h",
                     $realtime, what, got, want);
    endtask

    function automatic void push_region(input int unsigned off, input int unsigned size,
                                        input logic valid, input logic last);
        region_t r;
        r.offset = off[FIELD_W-1:0];
        r.size   = size[FIELD_W-1:0];
        r.valid  = valid;
        r.last   = last;
        pending_regions.insert(pending_regions.size(), r);
    endfunction

    function automatic void clear_shadow();
        shadow_bits    = '0;
        shadow_start   = '0;
        shadow_end     = '0;
        shadow_present = 1'b0;
    endfunction

    function automatic void widen_shadow(input logic [IDX_W-1:0] idx);
        logic [RIDX_W-1:0] lo;
        logic [RIDX_W-1:0] hi;
        lo = RIDX_W'(idx);
        hi = lo + 1'b1;
        if (!shadow_present)
        begin
            shadow_start   = lo;
            shadow_end     = hi;
            shadow_present = 1'b1;
        end
        else
        begin
            if (lo < shadow_start)
                shadow_start = lo;
            if (hi > shadow_end)
                shadow_end = hi;
        end
    endfunction

    // Merges set bits below the limit into byte regions, in ascending order.
    function automatic void coalesce_flush();
        int unsigned offs[64];
        int unsigned sizes[64];
        int unsigned eb;
        int unsigned off;
        int unsigned span;
        int n;
        eb = shadow_elem_bytes;
        n = 0;
        if (shadow_bits != '0)
        begin
            for (int unsigned i = 0; i < ENTRIES; i++)
            begin
                if (!shadow_bits[i] || i >= shadow_limit)
                    continue;
                off = i * eb;
                if (n > 0 && offs[n-1] + sizes[n-1] == off)
                    sizes[n-1] += eb;
                else if (n < 64)
                begin
                    offs[n]  = off;
                    sizes[n] = eb;
                    n++;
                end
                else
                    sizes[n-1] = off + eb - offs[n-1];
            end
            if (n == 0)
                push_region(0, 0, 1'b0, 1'b1);
            else
            begin
                for (int k = 0; k < n; k++)
                    push_region(offs[k], sizes[k], 1'b1, k == n - 1);
                clear_shadow();
            end
        end
        else if (shadow_present)
        begin
            span = (shadow_end >= shadow_start) ? shadow_end - shadow_start : 0;
            push_region(shadow_start * eb, span * eb, 1'b1, 1'b1);
            clear_shadow();
        end
        else
            push_region(0, 0, 1'b0, 1'b1);
    endfunction

    function automatic void track_cmd(input logic [1:0] code, input logic [IDX_W-1:0] idx);
        if (code == FUNC_FLUSH)
            coalesce_flush();
        else if (code == FUNC_MARK)
        begin
            shadow_bits[idx] = 1'b1;
            widen_shadow(idx);
        end
        else if (code == FUNC_WIDEN)
            widen_shadow(idx);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && result_strobe === 1'b1)
        begin
            if (pending_regions.size() == 0)
                report_mismatch("unexpected region", 32'(region_offset), 32'(0));
            else
            begin
                want_region = pending_regions.pop_front();
                if (region_offset !== want_region.offset)
                    report_mismatch("region_offset", 32'(region_offset),
                                    32'(want_region.offset));
                if (region_size !== want_region.size)
                    report_mismatch("region_size", 32'(region_size),
                                    32'(want_region.size));
                if (region_valid !== want_region.valid)
                    report_mismatch("region_valid", 32'(region_valid),
                                    32'(want_region.valid));
                if (last_region !== want_region.last)
                    report_mismatch("last_region", 32'(last_region),
                                    32'(want_region.last));
                regions_checked++;
            end
        end
    end

    // Sends one command; start stays high while a burst continues.
    task automatic send_cmd(input logic [1:0] code, input logic [IDX_W-1:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            if (!steady)
            begin
                gap = $urandom_range(0, 4);
                repeat (gap)
                begin
                    @(negedge clk);
                    start <= 1'b0;
                end
            end
        end
        burst_left--;
        @(negedge clk);
        start <= 1'b1;
        func <= code;
        element_index <= idx;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        track_cmd(code, idx);
        if (code != FUNC_UNUSED)
            cmds_taken++;
    endtask

    task automatic wait_idle(input int settle);
        @(negedge clk);
        start <= 1'b0;
        while (pending_regions.size() != 0)
            @(posedge clk);
        repeat (settle)
            @(negedge clk);
        while (busy !== 1'b0)
            @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t reg_sel, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= reg_sel;
        cfg_data <= value;
        @(posedge clk);
        if (reg_sel == CFG_ELEMENT_BYTES)
            shadow_elem_bytes = value[EB_W-1:0];
        else
            shadow_limit = value[LIMIT_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(input logic [CFG_DATA_W-1:0] elem_bytes,
                              input logic [CFG_DATA_W-1:0] limit);
        wait_idle(IDLE_SETTLE);
        write_reg(CFG_ELEMENT_BYTES, elem_bytes);
        write_reg(CFG_INDEX_LIMIT, limit);
        configs_used++;
    endtask

    task automatic test_empty_and_unused();
        send_cmd(FUNC_FLUSH, 7'd0);
        send_cmd(FUNC_UNUSED, 7'd127);
        send_cmd(FUNC_FLUSH, 7'd0);
    endtask

    task automatic test_index_extremes();
        send_cmd(FUNC_MARK, 7'd0);
        send_cmd(FUNC_MARK, 7'd127);
        send_cmd(FUNC_MARK, 7'd1);
        send_cmd(FUNC_WIDEN, 7'd64);
        send_cmd(FUNC_FLUSH, 7'd0);
        send_cmd(FUNC_FLUSH, 7'd127);
    endtask

    task automatic test_range_only();
        send_cmd(FUNC_WIDEN, 7'd127);
        send_cmd(FUNC_WIDEN, 7'd3);
        send_cmd(FUNC_FLUSH, 7'd0);
    endtask

    task automatic test_index_limit();
        set_config(13'd64, 13'd64);
        send_cmd(FUNC_MARK, 7'd63);
        send_cmd(FUNC_MARK, 7'd64);
        send_cmd(FUNC_FLUSH, 7'd0);
        // With a zero limit nothing qualifies, so the bits must survive the flush.
        set_config(13'd64, 13'd0);
        send_cmd(FUNC_MARK, 7'd5);
        send_cmd(FUNC_FLUSH, 7'd0);
        set_config(13'd64, 13'd255);
        send_cmd(FUNC_FLUSH, 7'd0);
    endtask

    task automatic test_element_size();
        // A zero element size folds every qualifying index into one empty region.
        set_config(13'd0, 13'd128);
        send_cmd(FUNC_MARK, 7'd2);
        send_cmd(FUNC_MARK, 7'd9);
        send_cmd(FUNC_FLUSH, 7'd0);
        send_cmd(FUNC_WIDEN, 7'd40);
        send_cmd(FUNC_FLUSH, 7'd0);
        set_config(13'd8191, 13'd128);
        send_cmd(FUNC_MARK, 7'd127);
        send_cmd(FUNC_MARK, 7'd126);
        send_cmd(FUNC_FLUSH, 7'd0);
        set_config(13'd4096, 13'd128);
        send_cmd(FUNC_WIDEN, 7'd0);
        send_cmd(FUNC_WIDEN, 7'd127);
        send_cmd(FUNC_FLUSH, 7'd0);
    endtask

    task automatic test_random();
        int phase;
        int phase_start;
        int target;
        int kind;
        int len;
        int base;
        int stride_base;
        logic [1:0] code;
        phase = 0;
        phase_start = cmds_taken;
        target = cmds_taken + RANDOM_CMDS;
        set_config(13'd1, 13'd128);
        while (cmds_taken < target)
        begin
            if (cmds_taken - phase_start >= PHASE_CMDS)
            begin
                phase++;
                phase_start = cmds_taken;
                steady = (phase % 3 == 1);
                case (phase)
                    1: set_config(13'd4096, 13'd0);
                    2: set_config(13'd8191, 13'd255);
                    3: set_config(13'd0, 13'd64);
                    default:
                        set_config(13'($urandom_range(1, 4096)),
                                   ($urandom_range(0, 3) == 0) ?
                                   13'($urandom_range(0, 8191)) :
                                   13'($urandom_range(0, 128)));
                endcase
            end
            kind = $urandom_range(0, 9);
            if (kind <= 5)
            begin
                // Clustered marks so that runs form, with some widens mixed in.
                len = $urandom_range(1, 12);
                base = $urandom_range(0, 127);
                repeat (len)
                begin
                    code = ($urandom_range(0, 3) == 0) ? FUNC_WIDEN : FUNC_MARK;
                    send_cmd(code, 7'(base + $urandom_range(0, 15)));
                end
                send_cmd(FUNC_FLUSH, 7'($urandom_range(0, 127)));
            end
            else if (kind == 6)
            begin
                len = $urandom_range(1, 4);
                repeat (len)
                    send_cmd(FUNC_WIDEN, 7'($urandom_range(0, 127)));
                send_cmd(FUNC_FLUSH, 7'($urandom_range(0, 127)));
            end
            else if (kind == 7)
            begin
                // Every other index gives the largest number of separate regions.
                len = $urandom_range(8, 64);
                stride_base = $urandom_range(0, 1);
                for (int k = 0; k < len; k++)
                    send_cmd(FUNC_MARK, 7'(stride_base + 2 * k));
                send_cmd(FUNC_FLUSH, 7'd0);
            end
            else if (kind == 8)
            begin
                len = $urandom_range(1, 6);
                repeat (len)
                    send_cmd(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
            end
            else
            begin
                send_cmd(FUNC_FLUSH, 7'($urandom_range(0, 127)));
                send_cmd(FUNC_FLUSH, 7'($urandom_range(0, 127)));
            end
        end
        steady = 1'b0;
    endtask

    initial
    begin
        clear_shadow();
        shadow_elem_bytes = 13'd64;
        shadow_limit = 8'd128;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_and_unused();
        test_index_extremes();
        test_range_only();
        test_index_limit();
        test_element_size();
        test_random();

        wait_idle(DRAIN_SETTLE);
        $display("tb: %0d commands sent, %0d regions checked", cmds_taken, regions_checked);
        $display("tb: %0d register settings, extremes of size and limit included",
                 configs_used);
        if (mismatches == 0 && pending_regions.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/dbrc_pkg.sv
src/dbrc_ram.sv
src/dbrc_seq.sv
src/dbrc_emit.sv
src/dirty_bitmap_region_coalescer.sv
src/dbrc_checker.sv
bench/tb_top.sv
